// ===== src/lfu_pkg.sv =====
// Shared types and constants for the LFU frame replacement unit.
// No dependencies; used by the top level.
package lfu_pkg;

   localparam int KEY_SPACE_DEF  = 128;
   localparam int MAX_FRAMES_DEF = 32;

   localparam int KEY_W   = 7;
   localparam int FRAME_W = 6;
   localparam int LIMIT_W = 7;
   localparam int COUNT_W = 10;
   localparam int STAMP_W = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = 10'd1023;
   localparam logic [FRAME_W-1:0] FRAME_RESET = 6'd3;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HIT_RD,
      ST_HIT_WR,
      ST_SCAN,
      ST_EVICT,
      ST_POST,
      ST_DONE
   } state_type;

endpackage

// ===== src/lfu_oldest_frame_replacement_unit.sv =====
// Top level of the LFU frame replacement unit with oldest-first tie-break.
// Depends on lfu_pkg and lfu_ram.
//
// The unit keeps up to frame_count posted keys out of KEY_SPACE keys. Each
// req word names a key. A hit on a posted key bumps its count (saturating at
// 1023). A miss while frames are free posts the key with count 1 and the
// current sequence stamp. A miss with all frames taken scans every key slot
// through the one read port of the count/stamp RAM, one slot per cycle,
// comparing each posted slot against the best candidate so far (lowest
// count, then largest age, then lowest id). A key_id at or above KEY_SPACE
// changes nothing. One word is worked on at a time; req_ready is high only
// while idle. The rsp word sits in an output register, so a new req word is
// taken while the previous rsp word still waits for rsp_ready. Posted state
// lives in one flip-flop per key slot, cleared by reset, so no clearing pass
// is needed. frame_count is written through csr_wr_en / csr_wr_data; 0 acts
// as 1 and values above MAX_FRAMES act as MAX_FRAMES. Write it only while
// idle.
module lfu_oldest_frame_replacement_unit #(
   parameter int KEY_SPACE  = lfu_pkg::KEY_SPACE_DEF,
   parameter int MAX_FRAMES = lfu_pkg::MAX_FRAMES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [lfu_pkg::KEY_W-1:0]   req_key_id,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_was_posted,
   output logic                        rsp_evict_valid,
   output logic [lfu_pkg::KEY_W-1:0]   rsp_evicted_id,
   output logic [lfu_pkg::FRAME_W-1:0] rsp_posted_count,
   input  logic                        csr_wr_en,
   input  logic [lfu_pkg::FRAME_W-1:0] csr_wr_data
);

   localparam int KW = $clog2(KEY_SPACE);
   localparam int CW = KW + 1;

   lfu_pkg::state_type state_ff, state_in;

   logic [KW-1:0]                 key_ff, key_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic                          cmp_vld_ff, cmp_vld_in;
   logic [KW-1:0]                 cmp_idx_ff, cmp_idx_in;
   logic                          found_ff, found_in;
   logic [KW-1:0]                 best_idx_ff, best_idx_in;
   logic [lfu_pkg::COUNT_W-1:0]   best_cnt_ff, best_cnt_in;
   logic [lfu_pkg::STAMP_W-1:0]   best_age_ff, best_age_in;
   logic [KEY_SPACE-1:0]          posted_ff, posted_in;
   logic [lfu_pkg::FRAME_W-1:0]   occupied_ff, occupied_in;
   logic [lfu_pkg::STAMP_W-1:0]   seq_ff, seq_in;
   logic [lfu_pkg::FRAME_W-1:0]   frame_count_ff, frame_count_in;
   logic                          res_posted_ff, res_posted_in;
   logic                          res_evict_ff, res_evict_in;
   logic [lfu_pkg::KEY_W-1:0]     res_evict_id_ff, res_evict_id_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_posted_ff, rsp_posted_in;
   logic                          rsp_evict_ff, rsp_evict_in;
   logic [lfu_pkg::KEY_W-1:0]     rsp_evict_id_ff, rsp_evict_id_in;
   logic [lfu_pkg::FRAME_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                          req_accept;
   logic                          key_in_range;
   logic [KW-1:0]                 req_idx;
   logic [lfu_pkg::LIMIT_W-1:0]   limit;
   logic                          frames_full;
   logic                          out_free;

   logic                          ram_wr_en;
   logic [KW-1:0]                 ram_wr_addr;
   lfu_pkg::entry_type            ram_wr_data;
   logic [KW-1:0]                 ram_rd_addr;
   lfu_pkg::entry_type            ram_rd_data;
   logic [lfu_pkg::STAMP_W-1:0]   cmp_age;
   logic                          cmp_better;

   lfu_ram #(
      .WIDTH ($bits(lfu_pkg::entry_type)),
      .DEPTH (KEY_SPACE)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready    = (state_ff == lfu_pkg::ST_IDLE);
   assign req_accept   = req_valid && req_ready;
   assign key_in_range = (32'(req_key_id) < KEY_SPACE);
   assign req_idx      = KW'(req_key_id);
   assign out_free     = !rsp_valid_ff || rsp_ready;

   // Effective frame limit: zero acts as one, clamp at MAX_FRAMES.
   always_comb begin
      if (frame_count_ff == '0) begin
         limit = lfu_pkg::LIMIT_W'(1);
      end else if (32'(frame_count_ff) > MAX_FRAMES) begin
         limit = lfu_pkg::LIMIT_W'(MAX_FRAMES);
      end else begin
         limit = lfu_pkg::LIMIT_W'(frame_count_ff);
      end
   end

   assign frames_full = (lfu_pkg::LIMIT_W'(occupied_ff) >= limit);

   // Shared compare unit: candidate from the RAM against the best so far.
   assign cmp_age    = seq_ff - ram_rd_data.stamp;
   assign cmp_better = !found_ff
                       || (ram_rd_data.count < best_cnt_ff)
                       || ((ram_rd_data.count == best_cnt_ff) && (cmp_age > best_age_ff));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lfu_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (!key_in_range) begin
                  state_in = lfu_pkg::ST_DONE;
               end else if (posted_ff[req_idx]) begin
                  state_in = lfu_pkg::ST_HIT_RD;
               end else if (frames_full) begin
                  state_in = lfu_pkg::ST_SCAN;
               end else begin
                  state_in = lfu_pkg::ST_POST;
               end
            end
         end
         lfu_pkg::ST_HIT_RD: state_in = lfu_pkg::ST_HIT_WR;
         lfu_pkg::ST_HIT_WR: state_in = lfu_pkg::ST_DONE;
         lfu_pkg::ST_SCAN: begin
            if (cnt_ff == CW'(KEY_SPACE)) begin
               state_in = lfu_pkg::ST_EVICT;
            end
         end
         lfu_pkg::ST_EVICT:  state_in = lfu_pkg::ST_POST;
         lfu_pkg::ST_POST:   state_in = lfu_pkg::ST_DONE;
         lfu_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = lfu_pkg::ST_IDLE;
            end
         end
         default:            state_in = lfu_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs of the sequencer.
   always_comb begin
      key_in          = key_ff;
      cnt_in          = cnt_ff;
      cmp_vld_in      = 1'b0;
      cmp_idx_in      = cnt_ff[KW-1:0];
      found_in        = found_ff;
      best_idx_in     = best_idx_ff;
      best_cnt_in     = best_cnt_ff;
      best_age_in     = best_age_ff;
      posted_in       = posted_ff;
      occupied_in     = occupied_ff;
      seq_in          = seq_ff;
      frame_count_in  = csr_wr_en ? csr_wr_data : frame_count_ff;
      res_posted_in   = res_posted_ff;
      res_evict_in    = res_evict_ff;
      res_evict_id_in = res_evict_id_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_posted_in   = rsp_posted_ff;
      rsp_evict_in    = rsp_evict_ff;
      rsp_evict_id_in = rsp_evict_id_ff;
      rsp_count_in    = rsp_count_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = key_ff;
      ram_wr_data     = ram_rd_data;
      ram_rd_addr     = key_ff;

      // Fold in the scan word that the registered RAM read returns.
      if (cmp_vld_ff && posted_ff[cmp_idx_ff] && cmp_better) begin
         found_in    = 1'b1;
         best_idx_in = cmp_idx_ff;
         best_cnt_in = ram_rd_data.count;
         best_age_in = cmp_age;
      end

      case (state_ff)
         lfu_pkg::ST_IDLE: begin
            if (req_accept) begin
               key_in          = req_idx;
               cnt_in          = '0;
               found_in        = 1'b0;
               res_posted_in   = 1'b0;
               res_evict_in    = 1'b0;
               res_evict_id_in = '0;
            end
         end
         lfu_pkg::ST_HIT_WR: begin
            // Bump the count, hold the stamp.
            ram_wr_en               = 1'b1;
            ram_wr_data.stamp       = ram_rd_data.stamp;
            ram_wr_data.count       = (ram_rd_data.count == lfu_pkg::COUNT_MAX)
                                      ? ram_rd_data.count : ram_rd_data.count + 1'b1;
            res_posted_in           = 1'b1;
            seq_in                  = seq_ff + 1'b1;
         end
         lfu_pkg::ST_SCAN: begin
            ram_rd_addr = cnt_ff[KW-1:0];
            if (cnt_ff != CW'(KEY_SPACE)) begin
               cmp_vld_in = 1'b1;
               cnt_in     = cnt_ff + 1'b1;
            end
         end
         lfu_pkg::ST_EVICT: begin
            if (found_ff) begin
               posted_in[best_idx_ff] = 1'b0;
               if (occupied_ff != '0) begin
                  occupied_in = occupied_ff - 1'b1;
               end
               res_evict_in    = 1'b1;
               res_evict_id_in = lfu_pkg::KEY_W'(best_idx_ff);
            end
         end
         lfu_pkg::ST_POST: begin
            ram_wr_en           = 1'b1;
            ram_wr_data.count   = lfu_pkg::COUNT_W'(1);
            ram_wr_data.stamp   = seq_ff;
            posted_in[key_ff]   = 1'b1;
            occupied_in         = occupied_ff + 1'b1;
            seq_in              = seq_ff + 1'b1;
         end
         lfu_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_posted_in   = res_posted_ff;
               rsp_evict_in    = res_evict_ff;
               rsp_evict_id_in = res_evict_id_ff;
               rsp_count_in    = occupied_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lfu_pkg::ST_IDLE;
         cmp_vld_ff     <= 1'b0;
         posted_ff      <= '0;
         occupied_ff    <= '0;
         seq_ff         <= '0;
         frame_count_ff <= lfu_pkg::FRAME_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cmp_vld_ff     <= cmp_vld_in;
         posted_ff      <= posted_in;
         occupied_ff    <= occupied_in;
         seq_ff         <= seq_in;
         frame_count_ff <= frame_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload and scan registers, no reset.
   always_ff @(posedge clock) begin
      key_ff          <= key_in;
      cnt_ff          <= cnt_in;
      cmp_idx_ff      <= cmp_idx_in;
      found_ff        <= found_in;
      best_idx_ff     <= best_idx_in;
      best_cnt_ff     <= best_cnt_in;
      best_age_ff     <= best_age_in;
      res_posted_ff   <= res_posted_in;
      res_evict_ff    <= res_evict_in;
      res_evict_id_ff <= res_evict_id_in;
      rsp_posted_ff   <= rsp_posted_in;
      rsp_evict_ff    <= rsp_evict_in;
      rsp_evict_id_ff <= rsp_evict_id_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_was_posted   = rsp_posted_ff;
   assign rsp_evict_valid  = rsp_evict_ff;
   assign rsp_evicted_id   = rsp_evict_id_ff;
   assign rsp_posted_count = rsp_count_ff;

endmodule

// ===== src/lfu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
